### hdl/ptd_pkg.sv
package ptd_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int COUNT_WIDTH = 16;
	// Trial divisors never pass the square root of the largest positive value.
	localparam int DIV_WIDTH = (VALUE_WIDTH + 1) / 2;

	localparam logic [VALUE_WIDTH-1:0] VALUE_TWO   = 2;
	localparam logic [DIV_WIDTH-1:0]   DIVISOR_FIRST = 2;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = '1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	typedef struct packed {
		logic                   start;
		logic [VALUE_WIDTH-1:0] dividend;
		logic [DIV_WIDTH-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic                   done;
		logic [VALUE_WIDTH-1:0] quot;
		logic [DIV_WIDTH-1:0]   rem;
	} div_res_t;

endpackage

### hdl/ptd_div.sv
module ptd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ptd_pkg::div_req_t  req,
	output ptd_pkg::div_res_t  res
);

	localparam int VW = ptd_pkg::VALUE_WIDTH;
	localparam int DW = ptd_pkg::DIV_WIDTH;
	localparam int CW = (VW > 1) ? $clog2(VW) : 1;

	logic [VW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0]   trial;
	logic [DW+1:0] diff;
	logic          fits;
	logic [DW-1:0] rem_next;

	// One restoring step per cycle: shift in the next dividend bit and subtract if it fits.
	always_comb begin
		trial    = {rem_q, quo_q[VW-1]};
		diff     = {1'b0, trial} - {2'b00, dvs_q};
		fits     = ~diff[DW+1];
		rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[VW-2:0], fits};
			rem_q <= rem_next;
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q;

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a finished division");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held for more than one cycle");

endmodule

### hdl/prime_count_trial_division_core.sv
// Primality test by trial division with a running prime count. Each transfer on the
// input gives exactly one result: the prime flag, the count of primes in the current
// array including this item (saturating at its maximum), and a copy of last; after a
// result marked last the count starts again from zero. Items are worked one at a time
// and in_stall is high from the input transfer until the result has been placed in
// the output register. Negative values, zero and one skip the divider and go straight
// to the done state. Any other value runs the divisors 2, 3, ... through one shared
// restoring divider that retires one quotient bit per cycle. A large prime near 2**31
// tries about 46340 divisors. While the output register still holds a result that
// has not been taken, a finished item waits and in_stall stays high. The output
// register keeps one result while the next item is already being tested.
module prime_count_trial_division_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [ptd_pkg::VALUE_WIDTH-1:0] value,
	input  logic                                  last,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  is_prime,
	output logic        [ptd_pkg::COUNT_WIDTH-1:0] prime_count,
	output logic                                  last_out
);

	localparam int VW = ptd_pkg::VALUE_WIDTH;
	localparam int DW = ptd_pkg::DIV_WIDTH;
	localparam int NW = ptd_pkg::COUNT_WIDTH;

	ptd_pkg::state_t   state_q;
	ptd_pkg::div_req_t div_req;
	ptd_pkg::div_res_t div_res;

	logic [VW-1:0] work_value_q;
	logic [DW-1:0] trial_divisor_q;
	logic          start_q;
	logic          prime_q;
	logic          last_q;
	logic [NW-1:0] running_count_q;
	logic          out_valid_q;
	logic          out_prime_q;
	logic [NW-1:0] out_count_q;
	logic          out_last_q;

	logic          in_xfer;
	logic          out_free;
	logic          finish;
	logic          below_two;
	logic          bound_passed;
	logic [NW-1:0] count_next;

	assign in_xfer   = in_valid && !in_stall;
	assign in_stall  = (state_q != ptd_pkg::ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign finish    = (state_q == ptd_pkg::ST_DONE) && out_free;
	assign below_two = value[VW-1] || ($unsigned(value) < ptd_pkg::VALUE_TWO);
	// The loop runs while d <= value / d; once the divisor passes the quotient, no factor is left.
	assign bound_passed = {{(VW-DW){1'b0}}, trial_divisor_q} > div_res.quot;

	always_comb begin
		count_next = running_count_q;
		if (prime_q && (running_count_q != ptd_pkg::COUNT_MAX)) begin
			count_next = running_count_q + 1'b1;
		end
	end

	assign div_req.start    = start_q;
	assign div_req.dividend = work_value_q;
	assign div_req.divisor  = trial_divisor_q;

	ptd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ptd_pkg::ST_IDLE;
			start_q         <= 1'b0;
			running_count_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ptd_pkg::ST_IDLE: begin
					if (in_xfer) begin
						if (below_two) begin
							state_q <= ptd_pkg::ST_DONE;
						end else begin
							state_q <= ptd_pkg::ST_DIV;
							start_q <= 1'b1;
						end
					end
				end
				ptd_pkg::ST_DIV: begin
					if (div_res.done) begin
						if (bound_passed || div_res.rem == '0) begin
							state_q <= ptd_pkg::ST_DONE;
						end else begin
							start_q <= 1'b1;
						end
					end
				end
				ptd_pkg::ST_DONE: begin
					if (out_free) begin
						state_q         <= ptd_pkg::ST_IDLE;
						out_valid_q     <= 1'b1;
						running_count_q <= last_q ? '0 : count_next;
					end
				end
				default: begin
					state_q <= ptd_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			work_value_q    <= $unsigned(value);
			last_q          <= last;
			trial_divisor_q <= ptd_pkg::DIVISOR_FIRST;
			prime_q         <= 1'b0;
		end else if ((state_q == ptd_pkg::ST_DIV) && div_res.done) begin
			if (bound_passed) begin
				prime_q <= 1'b1;
			end else if (div_res.rem != '0) begin
				trial_divisor_q <= trial_divisor_q + 1'b1;
			end
		end
		if (finish) begin
			out_prime_q <= prime_q;
			out_count_q <= count_next;
			out_last_q  <= last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign is_prime    = out_prime_q;
	assign prime_count = out_count_q;
	assign last_out    = out_last_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register lost its one-hot code");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == ptd_pkg::ST_DIV)
		else $error("division finished outside the trial loop");
	a_divisor_floor: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> trial_divisor_q >= ptd_pkg::DIVISOR_FIRST)
		else $error("trial divisor below two");
	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptd_pkg::ST_DONE) && out_valid_q && out_stall
		|=> state_q == ptd_pkg::ST_DONE && $stable(out_count_q))
		else $error("result overwrote a pending output");

endmodule

### bench/prime_count_trial_division_core_tb.sv
`timescale 1ns / 100ps

module prime_count_trial_division_core_tb;

	typedef struct {
		logic signed [ptd_pkg::VALUE_WIDTH-1:0] value;
		logic                                   last;
		bit                                     drain;
		bit                                     calm;
	} sample_t;

	typedef struct {
		logic                            is_prime;
		logic [ptd_pkg::COUNT_WIDTH-1:0] prime_count;
		logic                            last_out;
	} verdict_t;

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   in_valid = 1'b0;
	logic                                   in_stall;
	logic signed [ptd_pkg::VALUE_WIDTH-1:0] value = '0;
	logic                                   last = 1'b0;
	logic                                   out_valid;
	logic                                   out_stall = 1'b1;
	logic                                   is_prime;
	logic [ptd_pkg::COUNT_WIDTH-1:0]        prime_count;
	logic                                   last_out;

	sample_t  samples[$];
	verdict_t verdicts[$];
	verdict_t oldest;

	logic [ptd_pkg::COUNT_WIDTH-1:0] tally = '0;
	int sent_count = 0;
	int checked_count = 0;
	int fail_count = 0;
	int primes_seen = 0;
	int arrays_closed = 0;
	bit saturated = 1'b0;
	bit calm_mode = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	prime_count_trial_division_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.value       (value),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.is_prime    (is_prime),
		.prime_count (prime_count),
		.last_out    (last_out)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit trial_division_prime(logic signed [ptd_pkg::VALUE_WIDTH-1:0] v);
		longint n;
		longint d;
		n = v;
		if (n < 2)
			return 1'b0;
		for (d = 2; d * d <= n; d++)
			if (n % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic verdict_t predict_verdict(logic signed [ptd_pkg::VALUE_WIDTH-1:0] v,
			logic l);
		verdict_t r;
		r.is_prime = trial_division_prime(v);
		if (r.is_prime) begin
			primes_seen++;
			if (tally != ptd_pkg::COUNT_MAX)
				tally++;
			else
				saturated = 1'b1;
		end
		r.prime_count = tally;
		r.last_out = l;
		if (l) begin
			tally = '0;
			arrays_closed++;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what);
		fail_count++;
		$display("%0t ns: %s", $time, what);
	endtask

	task automatic add_sample(logic signed [ptd_pkg::VALUE_WIDTH-1:0] v, logic l,
			bit drain = 1'b0, bit calm = 1'b0);
		sample_t s;
		s.value = v;
		s.last = l;
		s.drain = drain;
		s.calm = calm;
		samples.push_back(s);
	endtask

	function automatic logic signed [ptd_pkg::VALUE_WIDTH-1:0] random_value();
		logic [ptd_pkg::VALUE_WIDTH-1:0] r;
		int unsigned f;
		r = $urandom;
		case ($urandom_range(0, 9))
			0: r = $signed($urandom_range(0, 8)) - 4;
			1, 2, 3: r = $urandom_range(0, 1000);
			4, 5: r = $urandom_range(0, 65535);
			6: r = r | 32'h8000_0000;
			default: begin
				// Large positive values are kept composite with a small factor, since a
				// large prime would run the divisor loop all the way to its square root.
				r = r & 32'h7fff_ffff;
				f = $urandom_range(2, 13);
				r = r - (r % f);
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
			last <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				verdicts.push_back(predict_verdict(value, last));
				sent_count <= sent_count + 1;
			end
			if (!(in_valid && in_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (samples.size() == 0) begin
					in_valid <= 1'b0;
				end else if (samples[0].drain && (in_valid || sent_count != checked_count)) begin
					in_valid <= 1'b0;
				end else if (!samples[0].calm && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 11);
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					value <= samples[0].value;
					last <= samples[0].last;
					calm_mode <= samples[0].calm;
					samples.delete(0);
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else begin
			if (out_valid && !out_stall) begin
				checked_count <= checked_count + 1;
				if (verdicts.size() == 0) begin
					report_mismatch("result transfer with no prediction outstanding");
				end else begin
					oldest = verdicts.pop_front();
					if (is_prime !== oldest.is_prime)
						report_mismatch($sformatf("is_prime got %b want %b",
							is_prime, oldest.is_prime));
					if (prime_count !== oldest.prime_count)
						report_mismatch($sformatf("prime_count got %0d want %0d",
							prime_count, oldest.prime_count));
					if (last_out !== oldest.last_out)
						report_mismatch($sformatf("last_out got %b want %b",
							last_out, oldest.last_out));
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_stall <= 1'b1;
			end else if (!calm_mode && $urandom_range(0, 5) == 0) begin
				recv_gap = $urandom_range(0, 11);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#(100_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		// Field extremes and the corner cases of the divisor loop.
		add_sample(0, 1'b0);
		add_sample(1, 1'b0);
		add_sample(-1, 1'b0);
		add_sample(32'sh8000_0000, 1'b0);
		add_sample(-7, 1'b0);
		add_sample(2, 1'b0);
		add_sample(3, 1'b0);
		add_sample(4, 1'b0);
		add_sample(5, 1'b0);
		add_sample(9, 1'b0);
		add_sample(25, 1'b0);
		add_sample(15, 1'b0);
		add_sample(17, 1'b0);
		add_sample(97, 1'b1);
		add_sample(2, 1'b0);
		add_sample(1042441, 1'b0);
		add_sample(65521, 1'b0);
		add_sample(65535, 1'b0);
		add_sample(1048573, 1'b0);
		// The largest positive value is itself prime and far too slow to test here.
		add_sample(32'sh7fff_fffe, 1'b0);
		add_sample(2147483645, 1'b0);
		add_sample(32'sh4000_0000, 1'b0);
		add_sample(7, 1'b1);

		for (int i = 0; i < 77; i++)
			add_sample(random_value(), $urandom_range(0, 7) == 0, i == 0 || i == 50, i >= 57);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (samples.size() != 0 || in_valid || sent_count != checked_count)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("Checked %0d results from %0d transfers in: %0d primes over %0d arrays.",
			checked_count, sent_count, primes_seen, arrays_closed);
		$display("Prime count saturation was %0s.", saturated ? "reached" : "not reached");
		if (fail_count == 0 && verdicts.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/ptd_pkg.sv
hdl/ptd_div.sv
hdl/prime_count_trial_division_core.sv
bench/prime_count_trial_division_core_tb.sv
